/* rtl/core/gdd_pkg.sv */
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int DN_W    = 23;
    localparam int DIFF_W  = 23;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

    localparam logic [12:0] RECIP_25  = 13'd5243;
    localparam int          RECIP_SH  = 17;
    localparam int          Q25_W     = 10;
    localparam int          Q100_W    = 8;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd0;
        case (m)
            MONTH_JAN: len = 5'd31;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_MAR: len = 5'd31;
            MONTH_APR: len = 5'd30;
            MONTH_MAY: len = 5'd31;
            MONTH_JUN: len = 5'd30;
            MONTH_JUL: len = 5'd31;
            MONTH_AUG: len = 5'd31;
            MONTH_SEP: len = 5'd30;
            MONTH_OCT: len = 5'd31;
            MONTH_NOV: len = 5'd30;
            MONTH_DEC: len = 5'd31;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, with the year starting in March.
    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] off;
        off = 9'd0;
        case (m)
            MONTH_MAR: off = 9'd0;
            MONTH_APR: off = 9'd31;
            MONTH_MAY: off = 9'd61;
            MONTH_JUN: off = 9'd92;
            MONTH_JUL: off = 9'd122;
            MONTH_AUG: off = 9'd153;
            MONTH_SEP: off = 9'd184;
            MONTH_OCT: off = 9'd214;
            MONTH_NOV: off = 9'd245;
            MONTH_DEC: off = 9'd275;
            MONTH_JAN: off = 9'd306;
            MONTH_FEB: off = 9'd337;
            default:   off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

/* rtl/core/gdd_day_num.sv */
module gdd_day_num (
    input  logic                          aclk,
    input  gdd_pkg::pipe_en_t             en,
    input  logic [gdd_pkg::DAY_W-1:0]     day,
    input  logic [gdd_pkg::MONTH_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]    year,
    output logic [gdd_pkg::DN_W-1:0]      day_num,
    output logic                          date_ok
);

    logic [gdd_pkg::DAY_W-1:0]   day_reg;
    logic [gdd_pkg::MONTH_W-1:0] month_reg;
    logic [gdd_pkg::YEAR_W-1:0]  year_reg;
    logic [gdd_pkg::YEAR_W-1:0]  yy_reg;
    logic [gdd_pkg::Q25_W-1:0]   q25_reg;
    logic [gdd_pkg::Q100_W-1:0]  q100_reg;
    logic [gdd_pkg::DOY_W-1:0]   doy_reg;
    logic [gdd_pkg::DN_W-1:0]    day_num_reg;
    logic                        date_ok_reg;

    logic [gdd_pkg::YEAR_W-1:0]  yy_next;
    logic [26:0]                 prod_y;
    logic [24:0]                 prod_yy;
    logic [gdd_pkg::DOY_W-1:0]   doy_next;

    logic [14:0]                 y25_back;
    logic                        leap;
    logic                        month_ok;
    logic                        year_ok;
    logic                        day_ok;
    logic [gdd_pkg::DAY_W-1:0]   len;
    logic [gdd_pkg::DN_W-1:0]    day_num_next;
    logic [gdd_pkg::DN_W-1:0]    yy_ext;
    logic [gdd_pkg::DN_W-1:0]    q100_ext;

    always_comb begin
        yy_next  = (month <= gdd_pkg::MONTH_FEB) ? year - 14'd1 : year;
        prod_y   = 27'(year) * 27'(gdd_pkg::RECIP_25);
        prod_yy  = 25'(yy_next[gdd_pkg::YEAR_W-1:2]) * 25'(gdd_pkg::RECIP_25);
        doy_next = gdd_pkg::month_offset(month) + 9'(day) - 9'd1;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            day_reg   <= day;
            month_reg <= month;
            year_reg  <= year;
            yy_reg    <= yy_next;
            q25_reg   <= prod_y[gdd_pkg::RECIP_SH +: gdd_pkg::Q25_W];
            q100_reg  <= prod_yy[gdd_pkg::RECIP_SH +: gdd_pkg::Q100_W];
            doy_reg   <= doy_next;
        end
    end

    always_comb begin
        y25_back = 15'(q25_reg) * 15'd25;
        leap     = (year_reg[1:0] == 2'd0) &&
                   ((y25_back != 15'(year_reg)) || (year_reg[3:0] == 4'd0));
        month_ok = (month_reg >= gdd_pkg::MONTH_JAN) && (month_reg <= gdd_pkg::MONTH_DEC);
        year_ok  = (year_reg != 14'd0) && (year_reg <= gdd_pkg::MAX_YEAR);
        len      = gdd_pkg::month_len(month_reg, leap);
        day_ok   = (day_reg != 5'd0) && (day_reg <= len);
        yy_ext   = gdd_pkg::DN_W'(yy_reg);
        q100_ext = gdd_pkg::DN_W'(q100_reg);
        day_num_next = yy_ext * 23'd365 + (yy_ext >> 2) - q100_ext + (q100_ext >> 2)
                     + gdd_pkg::DN_W'(doy_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            day_num_reg <= day_num_next;
            date_ok_reg <= month_ok && year_ok && day_ok;
        end
    end

    assign day_num = day_num_reg;
    assign date_ok = date_ok_reg;

endmodule

/* rtl/core/gdd_diff.sv */
module gdd_diff (
    input  logic                           aclk,
    input  gdd_pkg::pipe_en_t              en,
    input  logic [gdd_pkg::DN_W-1:0]       start_num,
    input  logic [gdd_pkg::DN_W-1:0]       end_num,
    input  logic                           start_ok,
    input  logic                           end_ok,
    input  logic                           include_end,
    output logic [gdd_pkg::DIFF_W-1:0]     day_difference,
    output logic                           invalid_date
);

    localparam int RAW_W = gdd_pkg::DN_W + 1;
    localparam int ADJ_W = RAW_W + 1;
    localparam logic signed [ADJ_W-1:0] SAT_MAX = ADJ_W'((2 ** (gdd_pkg::DIFF_W - 1)) - 1);
    localparam logic signed [ADJ_W-1:0] SAT_MIN = -ADJ_W'(2 ** (gdd_pkg::DIFF_W - 1));

    logic signed [RAW_W-1:0]          diff_reg;
    logic                             inc_reg;
    logic                             bad_reg;
    logic [gdd_pkg::DIFF_W-1:0]       result_reg;
    logic                             invalid_reg;

    logic signed [ADJ_W-1:0]          adj;
    logic [gdd_pkg::DIFF_W-1:0]       result_next;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            diff_reg <= $signed({1'b0, end_num}) - $signed({1'b0, start_num});
            inc_reg  <= include_end;
            bad_reg  <= !(start_ok && end_ok);
        end
    end

    always_comb begin
        adj = ADJ_W'(diff_reg);
        if (inc_reg) begin
            adj = diff_reg[RAW_W-1] ? adj - ADJ_W'(1) : adj + ADJ_W'(1);
        end
        if (bad_reg) begin
            result_next = '0;
        end else if (adj > SAT_MAX) begin
            result_next = SAT_MAX[gdd_pkg::DIFF_W-1:0];
        end else if (adj < SAT_MIN) begin
            result_next = SAT_MIN[gdd_pkg::DIFF_W-1:0];
        end else begin
            result_next = adj[gdd_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            result_reg  <= result_next;
            invalid_reg <= bad_reg;
        end
    end

    assign day_difference = result_reg;
    assign invalid_date   = invalid_reg;

endmodule

/* rtl/core/gregorian_date_difference.sv */
// An accepted input word is registered in stages s1, s2, s3 and s4, in that order, to give its result word.
// Throughput: one word per cycle; a stall on the master side holds every
// stage in place, and a bubble in the pipe is filled while the output waits.
// Reset (aresetn low, synchronous) clears all stage valid bits; the data
// registers keep their contents.
module gregorian_date_difference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
    // end_month[31:28], end_year[45:32], include_end[46], zero[47]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_difference[22:0], zero[23]
    output logic [23:0] m_tdata,
    // invalid_date[0]
    output logic        m_tuser
);

    gdd_pkg::pipe_en_t en;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic inc1_reg, inc2_reg;

    logic [gdd_pkg::DN_W-1:0]   start_num;
    logic [gdd_pkg::DN_W-1:0]   end_num;
    logic                       start_ok;
    logic                       end_ok;
    logic [gdd_pkg::DIFF_W-1:0] day_difference;
    logic                       invalid_date;

    always_comb begin
        en.s4 = !v4_reg || m_tready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign s_tready = en.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_tvalid;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg;
            end
            if (en.s4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            inc1_reg <= s_tdata[46];
        end
        if (en.s2) begin
            inc2_reg <= inc1_reg;
        end
    end

    gdd_day_num u_start (
        .aclk    (aclk),
        .en      (en),
        .day     (s_tdata[4:0]),
        .month   (s_tdata[8:5]),
        .year    (s_tdata[22:9]),
        .day_num (start_num),
        .date_ok (start_ok)
    );

    gdd_day_num u_end (
        .aclk    (aclk),
        .en      (en),
        .day     (s_tdata[27:23]),
        .month   (s_tdata[31:28]),
        .year    (s_tdata[45:32]),
        .day_num (end_num),
        .date_ok (end_ok)
    );

    gdd_diff u_diff (
        .aclk           (aclk),
        .en             (en),
        .start_num      (start_num),
        .end_num        (end_num),
        .start_ok       (start_ok),
        .end_ok         (end_ok),
        .include_end    (inc2_reg),
        .day_difference (day_difference),
        .invalid_date   (invalid_date)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {1'b0, day_difference};
    assign m_tuser  = invalid_date;

endmodule

/* rtl/core/gdd_checker.sv */
module gdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output word valid right after reset.");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output word dropped during a stall.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("Invalid date with a nonzero difference.");

    a_stall_after_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && $past(m_tvalid && !m_tready) && $past(!s_tready)
        |-> !s_tready)
        else $error("Input taken while the full pipe is stalled.");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);

/* sim/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_WORDS = 1400;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  HOLD_CYCLES  = 150;
    localparam int  DRAIN_CYCLES = 10;
    localparam longint SPAN_HI   = (longint'(1) <<< (gdd_pkg::DIFF_W - 1)) - 1;
    localparam longint SPAN_LO   = -(longint'(1) <<< (gdd_pkg::DIFF_W - 1));

    typedef struct packed {
        logic                        pad;
        logic                        include_end;
        logic [gdd_pkg::YEAR_W-1:0]  end_year;
        logic [gdd_pkg::MONTH_W-1:0] end_month;
        logic [gdd_pkg::DAY_W-1:0]   end_day;
        logic [gdd_pkg::YEAR_W-1:0]  start_year;
        logic [gdd_pkg::MONTH_W-1:0] start_month;
        logic [gdd_pkg::DAY_W-1:0]   start_day;
    } date_pair_t;

    typedef struct packed {
        logic                              invalid_date;
        logic signed [gdd_pkg::DIFF_W-1:0] day_difference;
    } span_t;

    typedef struct {
        int sd;
        int sm;
        int sy;
        int ed;
        int em;
        int ey;
        int inc;
        bit typed;
        int diff;
        bit bad;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    span_t pending_spans[$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    bit    no_idle = 1'b0;
    bit    burst_on = 1'b0;
    bit    hold_done = 1'b0;

    directed_row_t directed_rows[24];

    gregorian_date_difference dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            gdd_pkg::MONTH_FEB: return is_leap(y) ? 29 : 28;
            gdd_pkg::MONTH_APR, gdd_pkg::MONTH_JUN,
            gdd_pkg::MONTH_SEP, gdd_pkg::MONTH_NOV: return 30;
            gdd_pkg::MONTH_JAN, gdd_pkg::MONTH_MAR, gdd_pkg::MONTH_MAY,
            gdd_pkg::MONTH_JUL, gdd_pkg::MONTH_AUG, gdd_pkg::MONTH_OCT,
            gdd_pkg::MONTH_DEC: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
        return m >= gdd_pkg::MONTH_JAN && m <= gdd_pkg::MONTH_DEC && y >= 1 &&
               y <= gdd_pkg::MAX_YEAR && d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Days since March 1 of year 0, so that the leap day ends the year.
    function automatic longint day_index(int unsigned d, int unsigned m, int unsigned y);
        int unsigned yy;
        int unsigned mp;
        yy = (m <= gdd_pkg::MONTH_FEB) ? y - 1 : y;
        mp = (m + 9) % 12;
        return longint'(365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1);
    endfunction

    function automatic span_t predict_span(date_pair_t p);
        span_t  r;
        longint span;
        r = '0;
        if (!date_ok(p.start_day, p.start_month, p.start_year) ||
            !date_ok(p.end_day, p.end_month, p.end_year)) begin
            r.invalid_date = 1'b1;
            return r;
        end
        span = day_index(p.end_day, p.end_month, p.end_year) -
               day_index(p.start_day, p.start_month, p.start_year);
        if (p.include_end) begin
            span = (span < 0) ? span - 1 : span + 1;
        end
        if (span > SPAN_HI) span = SPAN_HI;
        if (span < SPAN_LO) span = SPAN_LO;
        r.day_difference = span[gdd_pkg::DIFF_W-1:0];
        return r;
    endfunction

    function automatic void pick_date(output logic [gdd_pkg::DAY_W-1:0] d,
                                      output logic [gdd_pkg::MONTH_W-1:0] m,
                                      output logic [gdd_pkg::YEAR_W-1:0] y);
        int unsigned len;
        if ($urandom_range(0, 2) == 0) begin
            y = gdd_pkg::YEAR_W'($urandom_range(1, 99) * 100 + $urandom_range(0, 8) - 4);
        end else begin
            y = gdd_pkg::YEAR_W'($urandom_range(1, gdd_pkg::MAX_YEAR));
        end
        m = gdd_pkg::MONTH_W'($urandom_range(gdd_pkg::MONTH_JAN, gdd_pkg::MONTH_DEC));
        len = days_in_month(m, y);
        d = gdd_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t                  p;
        int unsigned                 sel;
        int unsigned                 len;
        logic [gdd_pkg::DAY_W-1:0]   d;
        logic [gdd_pkg::MONTH_W-1:0] m;
        logic [gdd_pkg::YEAR_W-1:0]  y;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            p = 48'({$urandom, $urandom});
            p.pad = 1'b0;
            return p;
        end
        p = '0;
        pick_date(p.start_day, p.start_month, p.start_year);
        if (sel == 1) begin
            p.end_day = p.start_day;
            p.end_month = p.start_month;
            p.end_year = p.start_year;
        end else if (sel == 2) begin
            p.end_year = p.start_year;
            p.end_month = gdd_pkg::MONTH_W'($urandom_range(gdd_pkg::MONTH_JAN,
                                                           gdd_pkg::MONTH_DEC));
            p.end_day = gdd_pkg::DAY_W'($urandom_range(1, days_in_month(p.end_month,
                                                                        p.end_year)));
        end else begin
            pick_date(p.end_day, p.end_month, p.end_year);
        end
        p.include_end = 1'($urandom_range(0, 1));
        if (sel == 3) begin
            if ($urandom_range(0, 1) == 1) begin
                d = p.end_day;
                m = p.end_month;
                y = p.end_year;
            end else begin
                d = p.start_day;
                m = p.start_month;
                y = p.start_year;
            end
            len = days_in_month(m, y);
            case ($urandom_range(0, 2))
                0: d = gdd_pkg::DAY_W'((len == 31 || $urandom_range(0, 1) == 1) ? 0 :
                                       $urandom_range(len + 1, 31));
                1: m = gdd_pkg::MONTH_W'(($urandom_range(0, 1) == 1) ? 0 :
                                         $urandom_range(gdd_pkg::MONTH_DEC + 1, 15));
                default: y = gdd_pkg::YEAR_W'(($urandom_range(0, 1) == 1) ? 0 :
                             $urandom_range(gdd_pkg::MAX_YEAR + 1,
                                            (1 << gdd_pkg::YEAR_W) - 1));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                p.end_day = d;
                p.end_month = m;
                p.end_year = y;
            end else begin
                p.start_day = d;
                p.start_month = m;
                p.start_year = y;
            end
        end
        return p;
    endfunction

    task automatic send_pair(input date_pair_t p, input span_t e);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        pending_spans.push_back(e);
    endtask

    initial begin
        directed_row_t row;
        date_pair_t    p;
        span_t         e;
        directed_rows = '{
            '{1, 1, 1, 1, 1, 1, 0, 1, 0, 0},
            '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0},
            '{1, 1, 1, 31, 12, 9999, 0, 1, 3652058, 0},
            '{1, 1, 1, 31, 12, 9999, 1, 1, 3652059, 0},
            '{31, 12, 9999, 1, 1, 1, 0, 1, -3652058, 0},
            '{31, 12, 9999, 1, 1, 1, 1, 1, -3652059, 0},
            '{28, 2, 2000, 1, 3, 2000, 0, 0, 0, 0},
            '{29, 2, 2000, 29, 2, 2004, 1, 0, 0, 0},
            '{28, 2, 1900, 1, 3, 1900, 0, 0, 0, 0},
            '{29, 2, 1900, 1, 1, 2000, 0, 1, 0, 1},
            '{1, 1, 2000, 29, 2, 2100, 1, 1, 0, 1},
            '{1, 0, 2000, 1, 1, 2000, 0, 1, 0, 1},
            '{1, 13, 2000, 1, 1, 2000, 0, 1, 0, 1},
            '{1, 1, 2000, 1, 15, 2000, 1, 1, 0, 1},
            '{0, 1, 2000, 1, 1, 2000, 0, 1, 0, 1},
            '{1, 1, 2000, 31, 4, 2000, 0, 1, 0, 1},
            '{31, 1, 0, 1, 1, 2000, 0, 1, 0, 1},
            '{1, 1, 2000, 1, 1, 10000, 0, 1, 0, 1},
            '{1, 1, 16383, 1, 1, 1, 1, 1, 0, 1},
            '{31, 1, 2023, 1, 2, 2023, 0, 1, 1, 0},
            '{1, 2, 2023, 31, 1, 2023, 1, 1, -2, 0},
            '{15, 6, 1977, 4, 7, 2024, 1, 0, 0, 0},
            '{31, 12, 1999, 1, 1, 2000, 0, 1, 1, 0},
            '{0, 0, 0, 0, 0, 0, 1, 1, 0, 1}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            p = '0;
            p.start_day = gdd_pkg::DAY_W'(row.sd);
            p.start_month = gdd_pkg::MONTH_W'(row.sm);
            p.start_year = gdd_pkg::YEAR_W'(row.sy);
            p.end_day = gdd_pkg::DAY_W'(row.ed);
            p.end_month = gdd_pkg::MONTH_W'(row.em);
            p.end_year = gdd_pkg::YEAR_W'(row.ey);
            p.include_end = row.inc[0];
            if (row.typed) begin
                e.day_difference = gdd_pkg::DIFF_W'(row.diff);
                e.invalid_date = row.bad;
            end else begin
                e = predict_span(p);
            end
            send_pair(p, e);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // A back-to-back burst while the result side holds off fills the pipe.
            if (i == 500) begin
                no_idle = 1'b1;
                burst_on = 1'b1;
            end
            if (i == 700 || i == 1200) begin
                no_idle = 1'b0;
                burst_on = 1'b0;
            end
            if (i == 900) begin
                s_tvalid <= 1'b0;
                while (pending_spans.size() != 0) @(posedge aclk);
            end
            if (i == 1100) no_idle = 1'b1;
            p = random_pair();
            send_pair(p, predict_span(p));
        end
        s_tvalid <= 1'b0;

        while (pending_spans.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        int unsigned gap;
        span_t       e;
        wait (aresetn === 1'b1);
        forever begin
            if (burst_on && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (pending_spans.size() == 0) begin
                $display("%0t: result word with nothing expected, tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                e = pending_spans.pop_front();
                if (m_tdata[gdd_pkg::DIFF_W-1:0] !== e.day_difference) begin
                    $display("%0t: day_difference expected %0d, actual %0d", $time,
                             e.day_difference, $signed(m_tdata[gdd_pkg::DIFF_W-1:0]));
                    mismatch_count++;
                end
                if (m_tuser !== e.invalid_date) begin
                    $display("%0t: invalid_date expected %b, actual %b", $time,
                             e.invalid_date, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[23] !== 1'b0) begin
                    $display("%0t: tdata pad bit expected 0, actual %b", $time, m_tdata[23]);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
